@@ rtl/rar_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants of the rational add-and-reduce block
// Widths of the operands, the exact intermediate values and the result fields,
// and the packed beat types of the input and result channels.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int OPERAND_WIDTH   = 16;
    // Magnitudes of the unreduced numerator and denominator fit in 2W bits.
    localparam int MAG_WIDTH       = 2 * OPERAND_WIDTH;
    localparam int SUM_WIDTH       = 2 * OPERAND_WIDTH + 1;
    localparam int NUM_OUT_BITS    = 33;
    localparam int DEN_OUT_BITS    = 31;
    localparam int EXT_WIDTH       = (MAG_WIDTH > NUM_OUT_BITS) ? MAG_WIDTH : NUM_OUT_BITS;
    localparam int STEP_CNT_WIDTH  = $clog2(MAG_WIDTH);

    typedef struct packed {
        logic signed [OPERAND_WIDTH-1:0] num_a;
        logic signed [OPERAND_WIDTH-1:0] den_a;
        logic signed [OPERAND_WIDTH-1:0] num_b;
        logic signed [OPERAND_WIDTH-1:0] den_b;
    } rar_in_t;

    typedef struct packed {
        logic signed [NUM_OUT_BITS-1:0] sum_num;
        logic        [DEN_OUT_BITS-1:0] sum_den;
        logic                           den_error;
    } rar_out_t;

endpackage
`default_nettype wire

@@ rtl/rar_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rar_mul: shared signed multiplier with registered product
// One signed WIDTH x WIDTH product per cycle, registered and available in the cycle after its operands.
// ----------------------------------------------------------------------------
module rar_mul #(
    parameter int WIDTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic signed [WIDTH-1:0]   op_a,
    input  wire logic signed [WIDTH-1:0]   op_b,
    output logic signed [2*WIDTH-1:0]      product
);

    always_ff @(posedge aclk) begin
        product <= op_a * op_b;
    end

endmodule
`default_nettype wire

@@ rtl/rar_sub.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rar_sub: shared unsigned subtract-and-compare unit
// Gives op_a - op_b and a borrow that is set when op_a is less than op_b.
// ----------------------------------------------------------------------------
module rar_sub #(
    parameter int WIDTH = 33
) (
    input  wire logic [WIDTH-1:0] op_a,
    input  wire logic [WIDTH-1:0] op_b,
    output logic      [WIDTH-1:0] diff,
    output logic                  borrow
);

    assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};

endmodule
`default_nettype wire

@@ rtl/rational_add_reduce_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_add_reduce_top: adds two signed fractions and reduces the sum
// Forms (a*d + c*b)/(b*d) with one shared multiplier, finds the GCD of the
// magnitudes with a binary GCD on one shared subtractor, and divides both
// terms by it with a restoring divider on the same subtractor.
// ----------------------------------------------------------------------------
// Sequence: an input beat goes through the three products, the sum and the
//   magnitudes, the binary GCD (data dependent) and the two divisions; a zero
//   denominator gives its error result in the cycle after the input beat.
// Flow: one item at a time; s_ready is high only while idle, so a new item is
//   taken only once the result beat has been taken and the block is back in idle.
// Reset: synchronous active-low aresetn returns to idle and drops m_valid.
module rational_add_reduce_top
    import rar_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire rar_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output rar_out_t      m_data
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = MAG_WIDTH;
    localparam int CW = STEP_CNT_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_AD, ST_MUL_CB, ST_MUL_BD, ST_PREP,
        ST_GCD, ST_DIV_N, ST_DIV_D, ST_OUT
    } state_t;

    state_t                  state_reg;
    rar_in_t                 in_reg;
    logic signed [2*W-1:0]   p_ad_reg;
    logic signed [SUM_WIDTH-1:0] n_reg;
    logic [MW-1:0]           nmag_reg;
    logic [MW-1:0]           mmag_reg;
    logic                    neg_reg;
    logic [MW-1:0]           x_reg;
    logic [MW-1:0]           y_reg;
    logic [CW-1:0]           k_reg;
    logic [MW-1:0]           g_reg;
    logic [MW-1:0]           rem_reg;
    logic [MW-1:0]           quo_reg;
    logic [MW-1:0]           qn_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    m_valid_reg;
    rar_out_t                m_data_reg;

    // Shared multiplier.
    logic signed [W-1:0]     mul_a;
    logic signed [W-1:0]     mul_b;
    logic signed [2*W-1:0]   mul_p;

    always_comb begin
        unique case (state_reg)
            ST_MUL_CB: begin
                mul_a = in_reg.num_b;
                mul_b = in_reg.den_a;
            end
            ST_MUL_BD: begin
                mul_a = in_reg.den_a;
                mul_b = in_reg.den_b;
            end
            default: begin
                mul_a = in_reg.num_a;
                mul_b = in_reg.den_b;
            end
        endcase
    end

    rar_mul #(.WIDTH(W)) u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    // Shared subtractor: compares x and y during the GCD, and makes the trial
    // subtraction of the divider otherwise.
    logic [MW:0]   div_r2;
    logic [MW:0]   sub_a;
    logic [MW:0]   sub_b;
    logic [MW:0]   sub_diff;
    logic          sub_borrow;

    assign div_r2 = {rem_reg, quo_reg[MW-1]};
    assign sub_a  = (state_reg == ST_GCD) ? {1'b0, x_reg} : div_r2;
    assign sub_b  = (state_reg == ST_GCD) ? {1'b0, y_reg} : {1'b0, g_reg};

    rar_sub #(.WIDTH(MW + 1)) u_sub (
        .op_a   (sub_a),
        .op_b   (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    logic [MW-1:0] quo_step;
    logic [MW-1:0] rem_step;
    logic          div_last;

    assign quo_step = {quo_reg[MW-2:0], ~sub_borrow};
    assign rem_step = sub_borrow ? div_r2[MW-1:0] : sub_diff[MW-1:0];
    assign div_last = (cnt_reg == CW'(MW - 1));

    // Magnitudes and sign of the unreduced sum, valid in ST_PREP.
    logic signed [SUM_WIDTH-1:0] n_neg;
    logic signed [2*W-1:0]       m_neg;
    logic [MW-1:0]               nmag;
    logic [MW-1:0]               mmag;

    assign n_neg = -n_reg;
    assign m_neg = -mul_p;
    assign nmag  = n_reg[SUM_WIDTH-1] ? n_neg[MW-1:0] : n_reg[MW-1:0];
    assign mmag  = mul_p[2*W-1] ? m_neg : mul_p;

    // Result formatting from the two quotients.
    logic [EXT_WIDTH-1:0] qn_ext;
    logic [EXT_WIDTH-1:0] qd_ext;
    logic [EXT_WIDTH-1:0] sn_ext;

    assign qn_ext = EXT_WIDTH'(qn_reg);
    assign qd_ext = EXT_WIDTH'(quo_step);
    assign sn_ext = neg_reg ? -qn_ext : qn_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg <= s_data;
                        if (s_data.den_a == '0 || s_data.den_b == '0) begin
                            m_data_reg.sum_num   <= '0;
                            m_data_reg.sum_den   <= '0;
                            m_data_reg.den_error <= 1'b1;
                            m_valid_reg          <= 1'b1;
                            state_reg            <= ST_OUT;
                        end else begin
                            state_reg <= ST_MUL_AD;
                        end
                    end
                end
                ST_MUL_AD: begin
                    state_reg <= ST_MUL_CB;
                end
                ST_MUL_CB: begin
                    p_ad_reg  <= mul_p;
                    state_reg <= ST_MUL_BD;
                end
                ST_MUL_BD: begin
                    n_reg     <= SUM_WIDTH'(p_ad_reg) + SUM_WIDTH'(mul_p);
                    state_reg <= ST_PREP;
                end
                ST_PREP: begin
                    nmag_reg  <= nmag;
                    mmag_reg  <= mmag;
                    neg_reg   <= (n_reg != '0) && (n_reg[SUM_WIDTH-1] != mul_p[2*W-1]);
                    x_reg     <= nmag;
                    y_reg     <= mmag;
                    k_reg     <= '0;
                    state_reg <= ST_GCD;
                end
                ST_GCD: begin
                    // Binary GCD; y stays nonzero, so x reaching zero ends it.
                    if (x_reg == '0) begin
                        g_reg     <= y_reg << k_reg;
                        quo_reg   <= nmag_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV_N;
                    end else if (!x_reg[0] && !y_reg[0]) begin
                        x_reg <= x_reg >> 1;
                        y_reg <= y_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end else if (!x_reg[0]) begin
                        x_reg <= x_reg >> 1;
                    end else if (!y_reg[0]) begin
                        y_reg <= y_reg >> 1;
                    end else if (sub_borrow) begin
                        x_reg <= y_reg;
                        y_reg <= x_reg;
                    end else begin
                        // The difference of two odd values is even.
                        x_reg <= sub_diff[MW:1];
                    end
                end
                ST_DIV_N: begin
                    if (div_last) begin
                        qn_reg    <= quo_step;
                        quo_reg   <= mmag_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV_D;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                        quo_reg <= quo_step;
                        rem_reg <= rem_step;
                    end
                end
                ST_DIV_D: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    quo_reg <= quo_step;
                    rem_reg <= rem_step;
                    if (div_last) begin
                        m_data_reg.sum_num   <= sn_ext[NUM_OUT_BITS-1:0];
                        m_data_reg.sum_den   <= qd_ext[DEN_OUT_BITS-1:0];
                        m_data_reg.den_error <= 1'b0;
                        m_valid_reg          <= 1'b1;
                        state_reg            <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A result beat and a new input beat are never offered together.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

    // An accepted input beat closes the input side on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still ready after an accepted beat");

    // An error result carries zero fields.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.den_error |-> (m_data.sum_num == '0) && (m_data.sum_den == '0))
        else $error("error result with nonzero fields");

    // The divider runs only with a nonzero divisor.
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_N) || (state_reg == ST_DIV_D) |-> g_reg != '0)
        else $error("division by zero GCD");

endmodule
`default_nettype wire
